/* rtl/sma_pkg.sv */
// ----------------------------------------------------------------------------
// sma_pkg: shared types and codes of the stack machine arithmetic unit
// Opcodes, result kinds, error codes and the pipeline stage word.
// ----------------------------------------------------------------------------
package sma_pkg;

	localparam int DataW     = 64;
	localparam int HalfW     = DataW / 2;
	// one quotient bit per stage
	localparam int DivSteps  = DataW;
	// input register, then one stage per quotient bit
	localparam int LastStage = DivSteps + 1;

	typedef enum logic [2:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_MOD = 3'd4,
		FUNC_POS = 3'd5,
		FUNC_NEG = 3'd6,
		FUNC_ZERO = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		KIND_NUMBER  = 2'd0,
		KIND_BOOLEAN = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_TYPE    = 2'd1;
	localparam logic [1:0] ERR_DIVZERO = 2'd2;

	// where the final value comes from
	typedef enum logic [1:0] {
		SRC_RES = 2'd0,
		SRC_MUL = 2'd1,
		SRC_QUO = 2'd2,
		SRC_REM = 2'd3
	} src_t;

	typedef struct packed {
		logic [DataW-1:0] rem;
		logic [DataW-1:0] quo;
		logic [DataW-1:0] dvs;
		logic [DataW-1:0] res;
		src_t             src;
		kind_t            kind;
		logic [1:0]       err;
		logic [1:0]       pops;
		logic             failed;
	} stage_t;

endpackage

/* rtl/stack_machine_arith_unit_core.sv */
// ----------------------------------------------------------------------------
// stack_machine_arith_unit_core: execute unit for stack machine arithmetic
// Adds, subtracts, multiplies, divides, takes remainders and tests the top stack operands.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive func and the operand ports and raise start for one cycle per
//   word. busy stays low, so a word is taken on every cycle that start is high
//   and a new word may follow in every cycle.
//   Output: each word gives exactly one result, shown on the result ports for
//   one cycle while strobe is high. The receiver cannot stall the unit.
//   Pipeline: every opcode passes through all stages, from the input register
//   to the strobe; the restoring divider retires one quotient bit per stage
//   over 64 stages, and the multiplier (32x32 partial products, then a sum)
//   runs alongside the first stages. Throughput: one word per cycle.
//   Reset: arst_n clears all stage valid bits; words in flight are dropped.
// ----------------------------------------------------------------------------
module stack_machine_arith_unit_core
	import sma_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [2:0]       func,
	input  logic [DataW-1:0] top_value,
	input  logic             top_is_number,
	input  logic [DataW-1:0] second_value,
	input  logic             second_is_number,
	output logic             strobe,
	output logic [DataW-1:0] result_value,
	output logic [1:0]       result_kind,
	output logic [1:0]       error_code,
	output logic [1:0]       pops,
	output logic             op_failed
);

	logic [LastStage:1] vld_s;
	stage_t             pipe_s [LastStage:1];
	stage_t             next_s [LastStage:2];
	stage_t             entry;
	logic [DataW-1:0]   pp_ll_s2, pp_lh_s2, pp_hl_s2;
	logic [DataW-1:0]   mul_sum;
	logic               is_binary, tags_ok, div_zero;

	assign busy = 1'b0;

	// decode the word and settle errors and simple results
	always_comb begin
		is_binary = (func <= FUNC_MOD);
		tags_ok   = is_binary ? (top_is_number & second_is_number) : top_is_number;
		div_zero  = ((func == FUNC_DIV) || (func == FUNC_MOD)) && (second_value == '0);
		entry        = '0;
		entry.quo    = top_value;
		entry.dvs    = second_value;
		entry.src    = SRC_RES;
		entry.kind   = KIND_NUMBER;
		entry.err    = ERR_NONE;
		if (!tags_ok) begin
			entry.kind   = KIND_ERROR;
			entry.err    = ERR_TYPE;
			entry.failed = 1'b1;
		end else if (div_zero) begin
			entry.kind = KIND_ERROR;
			entry.err  = ERR_DIVZERO;
		end else begin
			case (func)
				FUNC_ADD: begin
					entry.res  = top_value + second_value;
					entry.pops = 2'd2;
				end
				FUNC_SUB: begin
					entry.res  = top_value - second_value;
					entry.pops = 2'd2;
				end
				FUNC_MUL: begin
					entry.src  = SRC_MUL;
					entry.pops = 2'd2;
				end
				FUNC_DIV: begin
					entry.src  = SRC_QUO;
					entry.pops = 2'd2;
				end
				FUNC_MOD: begin
					entry.src  = SRC_REM;
					entry.pops = 2'd2;
				end
				FUNC_POS: begin
					entry.kind = KIND_BOOLEAN;
					entry.pops = 2'd1;
					entry.res  = DataW'(~top_value[DataW-1] && (top_value != '0));
				end
				FUNC_NEG: begin
					entry.kind = KIND_BOOLEAN;
					entry.pops = 2'd1;
					entry.res  = DataW'(top_value[DataW-1]);
				end
				default: begin
					entry.kind = KIND_BOOLEAN;
					entry.pops = 2'd1;
					entry.res  = DataW'(top_value == '0);
				end
			endcase
		end
	end

	// sum the partial products for the low word of the product
	assign mul_sum = pp_ll_s2 + ((pp_lh_s2 + pp_hl_s2) << HalfW);

	// restoring divide step: one quotient bit per stage
	always_comb begin
		for (int k = 2; k <= LastStage; k++) begin
			logic [DataW:0] trial;
			trial = {pipe_s[k-1].rem, pipe_s[k-1].quo[DataW-1]};
			next_s[k] = pipe_s[k-1];
			if (trial >= {1'b0, pipe_s[k-1].dvs}) begin
				next_s[k].rem = DataW'(trial - {1'b0, pipe_s[k-1].dvs});
				next_s[k].quo = {pipe_s[k-1].quo[DataW-2:0], 1'b1};
			end else begin
				next_s[k].rem = trial[DataW-1:0];
				next_s[k].quo = {pipe_s[k-1].quo[DataW-2:0], 1'b0};
			end
			// drop the product in once its partial products are ready
			if (k == 3 && pipe_s[2].src == SRC_MUL)
				next_s[k].res = mul_sum;
		end
	end

	// advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LastStage-1:1], start & ~busy};
		end
	end

	// advance the stage words
	always_ff @(posedge clk) begin
		pipe_s[1] <= entry;
		for (int k = 2; k <= LastStage; k++)
			pipe_s[k] <= next_s[k];
		pp_ll_s2 <= pipe_s[1].quo[HalfW-1:0]     * pipe_s[1].dvs[HalfW-1:0];
		pp_lh_s2 <= pipe_s[1].quo[HalfW-1:0]     * pipe_s[1].dvs[DataW-1:HalfW];
		pp_hl_s2 <= pipe_s[1].quo[DataW-1:HalfW] * pipe_s[1].dvs[HalfW-1:0];
	end

	// select the result of the last stage
	always_comb begin
		strobe      = vld_s[LastStage];
		result_kind = pipe_s[LastStage].kind;
		error_code  = pipe_s[LastStage].err;
		pops        = pipe_s[LastStage].pops;
		op_failed   = pipe_s[LastStage].failed;
		case (pipe_s[LastStage].src)
			SRC_QUO: result_value = pipe_s[LastStage].quo;
			SRC_REM: result_value = pipe_s[LastStage].rem;
			default: result_value = pipe_s[LastStage].res;
		endcase
	end

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind == KIND_ERROR |-> result_value == '0)
		else $error("error result carries a nonzero value");

	a_fail_is_type: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && op_failed |-> error_code == ERR_TYPE && pops == 2'd0)
		else $error("failure flag without type mismatch");

	a_bool_range: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind == KIND_BOOLEAN |-> result_value[DataW-1:1] == '0
			&& pops == 2'd1)
		else $error("boolean result out of range");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[1] |-> ##(LastStage-1) strobe)
		else $error("word lost in the pipeline");

endmodule
